// File: src/brs_pkg.sv
`default_nettype none
package brs_pkg;

	localparam int ELEM_W       = 32;
	localparam int SUM_W        = 42;
	localparam int MAX_ELEMENTS = 1024;
	localparam int GRP_SIZE     = 32;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int OFS_W        = $clog2(GRP_SIZE);
	localparam int GRP_W        = ADDR_W - OFS_W;
	localparam int NUM_GROUPS   = MAX_ELEMENTS / GRP_SIZE;
	localparam int IDX_W        = ADDR_W + 1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic                     req_type;
		logic [ADDR_W-1:0]        elem_index;
		logic signed [ELEM_W-1:0] elem_value;
		logic [IDX_W-1:0]         left_index;
		logic [IDX_W-1:0]         right_index;
	} brs_req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] range_sum;
		logic                    range_error;
	} brs_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_SUB,
		ST_WR_ADD,
		ST_Q_WALK,
		ST_Q_DRAIN,
		ST_FIN
	} brs_state_t;

	// Controls from the sequencer to the shared adder datapath.
	typedef struct packed {
		logic             acc_clr;
		logic             walk_el;
		logic             walk_bs;
		logic             wr_sub;
		logic             wr_add;
		logic             out_load;
		logic [GRP_W-1:0] grp;
	} brs_ctl_t;

	function automatic logic signed [SUM_W-1:0] sext_elem(input logic [ELEM_W-1:0] v);
		return {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
	endfunction

endpackage
`default_nettype wire

// File: src/brs_elem_ram.sv
`default_nettype none
module brs_elem_ram (
	input  wire logic                         clk,
	input  wire logic                         re,
	input  wire logic                         we,
	input  wire logic [brs_pkg::ADDR_W-1:0]   addr,
	input  wire logic [brs_pkg::ELEM_W-1:0]   wdata,
	output logic      [brs_pkg::ELEM_W-1:0]   rdata
);
	import brs_pkg::*;

	logic [ELEM_W-1:0] mem_q [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// File: src/brs_datapath.sv
`default_nettype none
module brs_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire brs_pkg::brs_ctl_t             ctl,
	input  wire logic [brs_pkg::ELEM_W-1:0]    rdata,
	input  wire logic [brs_pkg::ELEM_W-1:0]    wdata,
	output logic signed [brs_pkg::SUM_W-1:0]   range_sum
);
	import brs_pkg::*;

	logic signed [SUM_W-1:0] bsums_q [NUM_GROUPS];
	logic signed [SUM_W-1:0] bsum_s1;
	logic                    add_el_s1;
	logic                    add_bs_s1;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] range_sum_q;
	logic        [SUM_W-1:0] op_a;
	logic        [SUM_W-1:0] op_b;
	logic                    cin;
	logic        [SUM_W-1:0] sum;

	// One adder serves both the block sum update and the query accumulation.
	always_comb begin
		op_a = acc_q;
		op_b = sext_elem(rdata);
		cin  = 1'b0;
		if (ctl.wr_sub) begin
			op_a = bsums_q[ctl.grp];
			op_b = ~sext_elem(rdata);
			cin  = 1'b1;
		end else if (ctl.wr_add) begin
			op_b = sext_elem(wdata);
		end else if (add_bs_s1) begin
			op_b = bsum_s1;
		end
		sum = op_a + op_b + {{(SUM_W-1){1'b0}}, cin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_el_s1 <= 1'b0;
			add_bs_s1 <= 1'b0;
			for (int i = 0; i < NUM_GROUPS; i++) begin
				bsums_q[i] <= '0;
			end
		end else begin
			add_el_s1 <= ctl.walk_el;
			add_bs_s1 <= ctl.walk_bs;
			if (ctl.wr_add) begin
				bsums_q[ctl.grp] <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.walk_bs) begin
			bsum_s1 <= bsums_q[ctl.grp];
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.wr_sub || add_el_s1 || add_bs_s1) begin
			acc_q <= sum;
		end
		if (ctl.out_load) begin
			range_sum_q <= acc_q;
		end
	end

	assign range_sum = range_sum_q;

endmodule
`default_nettype wire

// File: src/brs_ctrl.sv
`default_nettype none
module brs_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire brs_pkg::brs_req_t            req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              rsp_error,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [brs_pkg::IDX_W-1:0]    cfg_data,
	output brs_pkg::brs_ctl_t                 ctl,
	output logic                              ram_re,
	output logic                              ram_we,
	output logic [brs_pkg::ADDR_W-1:0]        ram_addr,
	output logic [brs_pkg::ELEM_W-1:0]        ram_wdata
);
	import brs_pkg::*;

	brs_state_t        state_q;
	brs_state_t        state_nxt;
	logic [IDX_W-1:0]  ptr_q;
	logic [ADDR_W-1:0] hi_q;
	logic [ELEM_W-1:0] wval_q;
	logic [IDX_W-1:0]  count_q;
	logic              err_q;
	logic              rsp_valid_q;
	logic              rsp_err_q;

	logic [IDX_W-1:0]  limit;
	logic              q_err;
	logic [ADDR_W-1:0] q_lo;
	logic [ADDR_W-1:0] q_hi;
	logic              whole;
	logic [IDX_W-1:0]  ptr_step;
	logic              walk_done;
	logic              accept;
	logic              load;

	always_comb begin
		limit = (count_q > IDX_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : count_q;
		q_err = (req.left_index == '0) || (req.left_index > req.right_index)
			|| (req.right_index > limit);
		q_lo  = ADDR_W'(req.left_index - IDX_W'(1));
		q_hi  = ADDR_W'(req.right_index - IDX_W'(1));
		// A whole block is taken from its running sum when the walk sits on
		// its first element and the range covers its last one.
		whole = (ptr_q[OFS_W-1:0] == '0)
			&& (({1'b0, ptr_q} + (IDX_W+1)'(GRP_SIZE - 1)) <= (IDX_W+1)'(hi_q));
		ptr_step  = whole ? (ptr_q + IDX_W'(GRP_SIZE)) : (ptr_q + IDX_W'(1));
		walk_done = ptr_step > IDX_W'(hi_q);
		accept    = (state_q == ST_IDLE) && req_valid;
		load      = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ptr_q == IDX_W'(MAX_ELEMENTS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type == REQ_WRITE) begin
						state_nxt = ST_WR_RD;
					end else if (q_err) begin
						state_nxt = ST_FIN;
					end else begin
						state_nxt = ST_Q_WALK;
					end
				end
			end
			ST_WR_RD:   state_nxt = ST_WR_SUB;
			ST_WR_SUB:  state_nxt = ST_WR_ADD;
			ST_WR_ADD:  state_nxt = ST_IDLE;
			ST_Q_WALK: begin
				if (walk_done) begin
					state_nxt = ST_Q_DRAIN;
				end
			end
			ST_Q_DRAIN: state_nxt = ST_FIN;
			ST_FIN: begin
				if (load) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall    = (state_q != ST_IDLE);
		cfg_ready    = 1'b1;
		ram_re       = (state_q == ST_WR_RD) || ((state_q == ST_Q_WALK) && !whole);
		ram_we       = (state_q == ST_CLEAR) || (state_q == ST_WR_SUB);
		ram_addr     = ptr_q[ADDR_W-1:0];
		ram_wdata    = (state_q == ST_CLEAR) ? '0 : wval_q;
		ctl.acc_clr  = accept;
		ctl.walk_el  = (state_q == ST_Q_WALK) && !whole;
		ctl.walk_bs  = (state_q == ST_Q_WALK) && whole;
		ctl.wr_sub   = (state_q == ST_WR_SUB);
		ctl.wr_add   = (state_q == ST_WR_ADD);
		ctl.out_load = load;
		ctl.grp      = ptr_q[ADDR_W-1:OFS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR:  ptr_q <= ptr_q + IDX_W'(1);
				ST_IDLE: begin
					if (req_valid) begin
						ptr_q <= (req.req_type == REQ_WRITE) ? {1'b0, req.elem_index}
							: {1'b0, q_lo};
					end
				end
				ST_Q_WALK: ptr_q <= ptr_step;
				default:   ptr_q <= ptr_q;
			endcase
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wval_q <= req.elem_value;
			hi_q   <= q_hi;
			err_q  <= q_err;
		end
		if (load) begin
			rsp_err_q <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_error = rsp_err_q;

endmodule
`default_nettype wire

// File: src/block_decomposed_range_sum.sv
// Write word: the old element is read and subtracted from its block sum, then the new
// value is added, before the next word is taken. Query word: an invalid range goes
// straight to the final state, which registers the result; otherwise N (at most 92)
// element reads and block sum reads run, one per cycle through the single shared
// adder, then a drain. One word is in work at a time; a finished result may wait in
// the output register. After reset all 1024 memory entries are cleared, one a cycle.
`default_nettype none
module block_decomposed_range_sum (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire brs_pkg::brs_req_t          req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output brs_pkg::brs_rsp_t               rsp,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [brs_pkg::IDX_W-1:0]  cfg_data
);
	import brs_pkg::*;

	brs_ctl_t                ctl;
	logic                    ram_re;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_addr;
	logic [ELEM_W-1:0]       ram_wdata;
	logic [ELEM_W-1:0]       ram_rdata;
	logic signed [SUM_W-1:0] range_sum;
	logic                    rsp_error;

	brs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_error (rsp_error),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.ram_re    (ram_re),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata)
	);

	brs_elem_ram u_ram (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	brs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rdata     (ram_rdata),
		.wdata     (ram_wdata),
		.range_sum (range_sum)
	);

	always_comb begin
		rsp.range_sum   = range_sum;
		rsp.range_error = rsp_error;
	end

endmodule
`default_nettype wire

// File: src/brs_checker.sv
`default_nettype none
module brs_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_stall,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_stall,
	input wire brs_pkg::brs_rsp_t          rsp
);
	import brs_pkg::*;

	// A result waiting on the output side holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// An error result always carries a zero sum.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.range_error |-> rsp.range_sum == '0)
		else $error("error result with nonzero sum");

	// The block works on one word at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second word taken while busy");

	// A new result only appears at the end of a word's work.
	a_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared with no word in work");

endmodule

bind block_decomposed_range_sum brs_checker u_chk (.*);
`default_nettype wire

// File: dv/block_decomposed_range_sum_tb.sv
`timescale 1ns / 1ps
module block_decomposed_range_sum_tb;
	import brs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	brs_req_t             req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	brs_rsp_t             rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_data;

	block_decomposed_range_sum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Mirror of the block's state.
	int               elem_mirror [MAX_ELEMENTS];
	longint           group_total [NUM_GROUPS];
	logic [IDX_W-1:0] count_mirror;

	brs_req_t words_to_send [$];
	brs_rsp_t sums_due [$];
	brs_rsp_t due_word;
	int       words_queued = 0;
	int       words_taken = 0;
	int       mismatch_count = 0;
	int       send_max = 0;
	int       recv_max = 0;
	int       send_gap = 0;
	int       recv_gap = 0;
	int       hold_left = 0;
	bit       hold_arm = 0;
	bit       hold_done = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("block_decomposed_range_sum verification failed");
		$finish;
	end

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t: %s", $time, what);
	endtask

	// Updates the mirror for one accepted word and, for a query, queues the sum it should produce.
	function automatic void apply_word(brs_req_t w);
		int unsigned lim, lo, hi, first_grp, last_grp, i;
		longint      acc;
		brs_rsp_t    res;
		if (w.req_type == REQ_WRITE) begin
			group_total[w.elem_index / GRP_SIZE] +=
				longint'(w.elem_value) - longint'(elem_mirror[w.elem_index]);
			elem_mirror[w.elem_index] = w.elem_value;
			return;
		end
		lim = (count_mirror < MAX_ELEMENTS) ? count_mirror : MAX_ELEMENTS;
		res.range_sum = '0;
		res.range_error = 1'b1;
		if (w.left_index != 0 && w.left_index <= w.right_index && w.right_index <= lim) begin
			lo = w.left_index - 1;
			hi = w.right_index - 1;
			first_grp = lo / GRP_SIZE;
			last_grp = hi / GRP_SIZE;
			acc = 0;
			if (first_grp == last_grp) begin
				for (i = lo; i <= hi; i++)
					acc += elem_mirror[i];
			end else begin
				for (i = lo; i < (first_grp + 1) * GRP_SIZE; i++)
					acc += elem_mirror[i];
				for (i = first_grp + 1; i < last_grp; i++)
					acc += group_total[i];
				for (i = last_grp * GRP_SIZE; i <= hi; i++)
					acc += elem_mirror[i];
			end
			res.range_sum = acc[SUM_W-1:0];
			res.range_error = 1'b0;
		end
		sums_due.push_back(res);
	endfunction

	function automatic brs_req_t write_word(input int unsigned idx, input logic [31:0] val);
		brs_req_t w;
		w.req_type = REQ_WRITE;
		w.elem_index = ADDR_W'(idx);
		w.elem_value = val;
		w.left_index = IDX_W'($urandom);
		w.right_index = IDX_W'($urandom);
		return w;
	endfunction

	function automatic brs_req_t query_word(input int unsigned l, input int unsigned r);
		brs_req_t w;
		w.req_type = REQ_QUERY;
		w.elem_index = ADDR_W'($urandom);
		w.elem_value = $urandom;
		w.left_index = IDX_W'(l);
		w.right_index = IDX_W'(r);
		return w;
	endfunction

	function automatic void queue_word(brs_req_t w);
		words_to_send.push_back(w);
		words_queued++;
	endfunction

	// Mostly writes and in-range queries, with some malformed ranges mixed in.
	function automatic void queue_burst(input int n);
		int unsigned lim, l, r, pick, span;
		logic [31:0] val;
		lim = (count_mirror < MAX_ELEMENTS) ? count_mirror : MAX_ELEMENTS;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				val = $urandom;
				if (pick < 4)
					val = 32'h7FFF_FFFF;
				else if (pick < 8)
					val = 32'h8000_0000;
				queue_word(write_word($urandom_range(0, MAX_ELEMENTS - 1), val));
			end else if (pick < 55 || lim == 0) begin
				queue_word(query_word($urandom_range(0, 2047), $urandom_range(0, 2047)));
			end else if (pick < 60) begin
				queue_word(query_word($urandom_range(1, lim), lim + 1));
			end else begin
				r = $urandom_range(1, lim);
				span = (r - 1 < 40) ? r - 1 : 40;
				if (pick < 78)
					l = r - $urandom_range(0, span);
				else
					l = $urandom_range(1, r);
				queue_word(query_word(l, r));
			end
		end
	endfunction

	task automatic set_count(input logic [IDX_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		count_mirror = v;
		cfg_valid <= 1'b0;
	endtask

	// Waits until every word is taken and every sum has come back, then a tail.
	task automatic settle(input int tail);
		while (words_taken != words_queued || sums_due.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Word driver.
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			apply_word(req);
			words_taken++;
		end
		if (!req_valid || !req_stall) begin
			if (send_gap != 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				req <= words_to_send.pop_front();
				req_valid <= 1'b1;
				send_gap = $urandom_range(0, send_max);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, armed once.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (sums_due.size() == 0) begin
				note_mismatch($sformatf("unexpected result: sum %0d error %0b",
					rsp.range_sum, rsp.range_error));
			end else begin
				due_word = sums_due.pop_front();
				if (rsp.range_sum !== due_word.range_sum)
					note_mismatch($sformatf("range_sum %0d, expected %0d",
						rsp.range_sum, due_word.range_sum));
				if (rsp.range_error !== due_word.range_error)
					note_mismatch($sformatf("range_error %0b, expected %0b",
						rsp.range_error, due_word.range_error));
			end
			recv_gap = $urandom_range(0, recv_max);
		end else if (rsp_valid && recv_gap != 0) begin
			recv_gap--;
		end
		rsp_stall <= (recv_gap != 0) || (hold_left != 0);
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		count_mirror = '0;
		foreach (elem_mirror[i])
			elem_mirror[i] = 0;
		foreach (group_total[i])
			group_total[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// With no valid elements every query is out of range.
		set_count(IDX_W'(0));
		queue_word(query_word(1, 1));
		queue_word(query_word(0, 0));
		settle(8);

		set_count(IDX_W'(MAX_ELEMENTS));
		queue_word(write_word(0, 32'h7FFF_FFFF));
		queue_word(write_word(1023, 32'h8000_0000));
		queue_word(write_word(31, 32'hFFFF_FFFF));
		queue_word(write_word(32, 12345));
		queue_word(write_word(0, -5));
		queue_word(write_word(500, 32'h7FFF_FFFF));
		queue_word(query_word(1, 1));
		queue_word(query_word(1, 1024));
		queue_word(query_word(1024, 1024));
		queue_word(query_word(2, 31));
		queue_word(query_word(31, 34));
		queue_word(query_word(1, 32));
		queue_word(query_word(33, 64));
		queue_word(query_word(5, 700));
		queue_word(query_word(0, 5));
		queue_word(query_word(10, 9));
		queue_word(query_word(1, 1025));
		queue_word(query_word(2047, 2047));
		queue_word(query_word(1, 2047));
		settle(8);

		// A write above the element count is still stored.
		set_count(IDX_W'(40));
		queue_word(write_word(100, 77));
		queue_word(query_word(1, 40));
		queue_word(query_word(1, 41));
		queue_word(query_word(40, 40));
		settle(8);

		// A count above capacity behaves as full capacity.
		set_count(11'h7FF);
		queue_word(query_word(101, 101));
		queue_word(query_word(1, 1024));
		send_max = 6;
		recv_max = 6;
		queue_burst(200);
		settle(8);

		set_count(IDX_W'($urandom_range(1, 1023)));
		send_max = 0;
		recv_max = 0;
		queue_burst(200);
		settle(8);

		// Receiver holds off while the sender keeps offering words.
		set_count(IDX_W'(MAX_ELEMENTS));
		send_max = 6;
		recv_max = 6;
		queue_burst(200);
		hold_arm <= 1'b1;
		settle(8);

		set_count(IDX_W'($urandom_range(1, 64)));
		send_max = 6;
		recv_max = 0;
		queue_burst(100);
		settle(8);

		set_count(IDX_W'(MAX_ELEMENTS));
		send_max = 0;
		recv_max = 6;
		queue_burst(100);
		settle(120);

		if (mismatch_count == 0)
			$display("block_decomposed_range_sum verification clean");
		else
			$display("block_decomposed_range_sum verification failed");
		$finish;
	end

endmodule

// File: block_decomposed_range_sum.f
src/brs_pkg.sv
src/brs_elem_ram.sv
src/brs_datapath.sv
src/brs_ctrl.sv
src/block_decomposed_range_sum.sv
src/brs_checker.sv
dv/block_decomposed_range_sum_tb.sv
